// File: rtl/core/char_gap_buffer_top_defines.svh
// ---------------------------------------------------------------------------
// Character gap buffer: shared assertion macros
// Concurrent assertion wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CHAR_GAP_BUFFER_TOP_DEFINES_SVH
`define CHAR_GAP_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CGB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CGB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// File: rtl/core/cgb_pkg.sv
// ---------------------------------------------------------------------------
// Character gap buffer package
// Operation codes, field widths and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package cgb_pkg;

   // Field widths of the request and response items.
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int DIST_W = 9;
   localparam int POS_W  = 8;
   localparam int OUT_W  = 8;
   // A move count holds the magnitude of a 9-bit signed distance.
   localparam int CNT_W  = 9;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
   localparam logic [OP_W-1:0] OP_MOVE      = 2'd2;
   localparam logic [OP_W-1:0] OP_READ      = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the accepted request
      logic insert;      // write the byte at the cursor and advance
      logic backspace;   // give back the cell left of the gap
      logic read_char;   // start a store read at the mapped position
      logic move_read;   // read the character about to cross the gap
      logic move_write;  // write it on the far side and step the gap
      logic refuse;      // mark the operation as refused
      logic respond;     // load the response register
   } cgb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            at_start;
      logic            move_bad;
      logic            move_zero;
      logic            read_bad;
      logic            last_step;
      logic            out_free;
   } cgb_stat_type;

endpackage

// File: rtl/core/char_gap_buffer_top.sv
// ---------------------------------------------------------------------------
// Character gap buffer top level
// Gap buffer over a byte store with insert, backspace, move and read.
//
//   Channel   Direction   Handshake             Payload
//   req       in          req_valid/req_ready   operation, char_in,
//                                               move_distance, read_position
//   rsp       out         rsp_valid/rsp_ready   status, cursor_pos,
//                                               text_length, char_out
//
// One operation is in flight at a time. Insert, backspace, read and refused
// operations go from the decode state to the finish state, which waits for a
// free response register; a move of distance d adds one store read and one
// store write per character carried across the gap through the single store.
// Reset clears the gap pointers and the control state; the store is not
// cleared. A stalled response is held while the next request is accepted.
// ---------------------------------------------------------------------------
module char_gap_buffer_top
   import cgb_pkg::*;
#(
   parameter int STORE_SIZE = 256
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [CHAR_W-1:0]        req_char_in,
   input  logic signed [DIST_W-1:0] req_move_distance,
   input  logic [POS_W-1:0]         req_read_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_status,
   output logic [OUT_W-1:0]         rsp_cursor_pos,
   output logic [OUT_W-1:0]         rsp_text_length,
   output logic [CHAR_W-1:0]        rsp_char_out
);

   cgb_cmd_type  cmd;
   cgb_stat_type stat;

   // Operation sequencer.
   cgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, pointers and response register.
   cgb_datapath #(
      .STORE_SIZE (STORE_SIZE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_char_in       (req_char_in),
      .req_move_distance (req_move_distance),
      .req_read_position (req_read_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_cursor_pos    (rsp_cursor_pos),
      .rsp_text_length   (rsp_text_length),
      .rsp_char_out      (rsp_char_out)
   );

endmodule

// File: rtl/core/cgb_ctrl.sv
// ---------------------------------------------------------------------------
// Character gap buffer controller
// Sequences one operation at a time: decode, move steps and response load.
// ---------------------------------------------------------------------------
module cgb_ctrl
   import cgb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  cgb_stat_type stat,
   output cgb_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_EXEC    = 3'd1;
   localparam logic [2:0] ST_MOVE_RD = 3'd2;
   localparam logic [2:0] ST_MOVE_WR = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            unique case (stat.op)
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.refuse = 1'b1;
                  end else begin
                     cmd.insert = 1'b1;
                  end
               end
               OP_BACKSPACE: begin
                  if (stat.at_start) begin
                     cmd.refuse = 1'b1;
                  end else begin
                     cmd.backspace = 1'b1;
                  end
               end
               OP_MOVE: begin
                  if (stat.move_bad) begin
                     cmd.refuse = 1'b1;
                  end else if (!stat.move_zero) begin
                     state_in = ST_MOVE_RD;
                  end
               end
               OP_READ: begin
                  if (stat.read_bad) begin
                     cmd.refuse = 1'b1;
                  end else begin
                     cmd.read_char = 1'b1;
                  end
               end
               default: begin
                  cmd.refuse = 1'b1;
               end
            endcase
         end
         ST_MOVE_RD: begin
            cmd.move_read = 1'b1;
            state_in      = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            cmd.move_write = 1'b1;
            state_in       = stat.last_step ? ST_FINISH : ST_MOVE_RD;
         end
         ST_FINISH: begin
            // Hold here until the response register can take the result.
            if (stat.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/cgb_datapath.sv
// ---------------------------------------------------------------------------
// Character gap buffer datapath
// Text store, gap pointers, request capture, checks and response register.
// ---------------------------------------------------------------------------
module cgb_datapath
   import cgb_pkg::*;
#(
   parameter int STORE_SIZE = 256
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  cgb_cmd_type              cmd,
   output cgb_stat_type             stat,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [CHAR_W-1:0]        req_char_in,
   input  logic signed [DIST_W-1:0] req_move_distance,
   input  logic [POS_W-1:0]         req_read_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_status,
   output logic [OUT_W-1:0]         rsp_cursor_pos,
   output logic [OUT_W-1:0]         rsp_text_length,
   output logic [CHAR_W-1:0]        rsp_char_out
);

   localparam int PTR_W  = $clog2(STORE_SIZE);
   // Wide enough for signed pointer sums and the 8-bit output slices.
   localparam int CALC_W = ((PTR_W > DIST_W) ? PTR_W : DIST_W) + 2;
   localparam logic [PTR_W-1:0]         LAST_CELL  = PTR_W'(STORE_SIZE - 2);
   localparam logic [CALC_W-1:0]        LAST_EXT   = CALC_W'(STORE_SIZE - 2);
   localparam logic signed [CALC_W-1:0] MOVE_LIMIT = CALC_W'(STORE_SIZE - 1);

   logic [CHAR_W-1:0] text_mem [STORE_SIZE];

   logic [OP_W-1:0]   op_ff,      op_in;
   logic [CHAR_W-1:0] char_ff,    char_in;
   logic [DIST_W-1:0] dist_ff,    dist_in;
   logic [POS_W-1:0]  pos_ff,     pos_in;
   logic [CNT_W-1:0]  count_ff,   count_in;
   logic [PTR_W-1:0]  gs_ff,      gs_in;
   logic [PTR_W-1:0]  ge_ff,      ge_in;
   logic              refused_ff, refused_in;
   logic [CHAR_W-1:0] rd_data_ff;
   logic              rsp_valid_ff,  rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [OUT_W-1:0]  rsp_cursor_ff, rsp_cursor_in;
   logic [OUT_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [CHAR_W-1:0] rsp_char_ff,   rsp_char_in;

   logic [CALC_W-1:0] gs_ext;
   logic [CALC_W-1:0] ge_ext;
   logic [CALC_W-1:0] dist_ext;
   logic [CALC_W-1:0] pos_ext;
   logic [CALC_W-1:0] left_sum;
   logic [CALC_W-1:0] right_sum;
   logic [CALC_W-1:0] text_len;
   logic [CALC_W-1:0] far_addr;
   logic [PTR_W-1:0]  read_addr;
   logic              moving_left;
   logic [PTR_W-1:0]  move_src;
   logic [PTR_W-1:0]  move_dst;
   logic [CNT_W-1:0]  dist_mag;
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;
   logic              mem_re;
   logic [PTR_W-1:0]  mem_raddr;

   // Extended operands for range checks and address mapping.
   assign gs_ext    = CALC_W'(gs_ff);
   assign ge_ext    = CALC_W'(ge_ff);
   assign dist_ext  = {{(CALC_W - DIST_W){dist_ff[DIST_W-1]}}, dist_ff};
   assign pos_ext   = CALC_W'(pos_ff);
   assign left_sum  = gs_ext + dist_ext;
   assign right_sum = ge_ext + dist_ext;
   assign text_len  = gs_ext + LAST_EXT - ge_ext;

   // A logical position right of the cursor lies beyond the gap end.
   assign far_addr  = ge_ext + pos_ext - gs_ext + CALC_W'(1);
   assign read_addr = (pos_ext < gs_ext) ? pos_ext[PTR_W-1:0] : far_addr[PTR_W-1:0];

   // One move step carries one character across the gap.
   assign moving_left = dist_ff[DIST_W-1];
   assign move_src    = moving_left ? (gs_ff - PTR_W'(1)) : (ge_ff + PTR_W'(1));
   assign move_dst    = moving_left ? ge_ff : gs_ff;
   assign dist_mag    = req_move_distance[DIST_W-1] ?
                        (CNT_W'(0) - CNT_W'(req_move_distance)) : CNT_W'(req_move_distance);

   // Status toward the controller.
   always_comb begin
      stat.op        = op_ff;
      stat.full      = (gs_ff == ge_ff);
      stat.at_start  = (gs_ff == '0);
      stat.move_bad  = left_sum[CALC_W-1] || ($signed(right_sum) >= MOVE_LIMIT);
      stat.move_zero = (dist_ff == '0);
      stat.read_bad  = (pos_ext >= text_len);
      stat.last_step = (count_ff == CNT_W'(1));
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Next values of the request and pointer registers.
   always_comb begin
      op_in      = op_ff;
      char_in    = char_ff;
      dist_in    = dist_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      gs_in      = gs_ff;
      ge_in      = ge_ff;
      refused_in = refused_ff;
      if (cmd.load) begin
         op_in      = req_operation;
         char_in    = req_char_in;
         dist_in    = req_move_distance;
         pos_in     = req_read_position;
         count_in   = dist_mag;
         refused_in = 1'b0;
      end
      if (cmd.refuse) begin
         refused_in = 1'b1;
      end
      if (cmd.insert) begin
         gs_in = gs_ff + PTR_W'(1);
      end
      if (cmd.backspace) begin
         gs_in = gs_ff - PTR_W'(1);
      end
      if (cmd.move_write) begin
         count_in = count_ff - CNT_W'(1);
         if (moving_left) begin
            gs_in = gs_ff - PTR_W'(1);
            ge_in = ge_ff - PTR_W'(1);
         end else begin
            gs_in = gs_ff + PTR_W'(1);
            ge_in = ge_ff + PTR_W'(1);
         end
      end
   end

   // Store port selection.
   assign mem_we    = cmd.insert || cmd.move_write;
   assign mem_waddr = cmd.insert ? gs_ff : move_dst;
   assign mem_wdata = cmd.insert ? char_ff : rd_data_ff;
   assign mem_re    = cmd.read_char || cmd.move_read;
   assign mem_raddr = cmd.read_char ? read_addr : move_src;

   // Text store with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= text_mem[mem_raddr];
      end
   end

   // Response register: loaded once per operation, cleared on transfer.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_length_in = rsp_length_ff;
      rsp_char_in   = rsp_char_ff;
      if (cmd.respond) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = refused_ff;
         rsp_cursor_in = gs_ext[OUT_W-1:0];
         rsp_length_in = text_len[OUT_W-1:0];
         rsp_char_in   = ((op_ff == OP_READ) && !refused_ff) ? rd_data_ff : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      char_ff       <= char_in;
      dist_ff       <= dist_in;
      pos_ff        <= pos_in;
      count_ff      <= count_in;
      refused_ff    <= refused_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_length_ff <= rsp_length_in;
      rsp_char_ff   <= rsp_char_in;
   end

   // Gap pointers and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff        <= '0;
         ge_ff        <= LAST_CELL;
         rsp_valid_ff <= 1'b0;
      end else begin
         gs_ff        <= gs_in;
         ge_ff        <= ge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_cursor_pos  = rsp_cursor_ff;
   assign rsp_text_length = rsp_length_ff;
   assign rsp_char_out    = rsp_char_ff;

endmodule

// File: rtl/core/cgb_checker.sv
// ---------------------------------------------------------------------------
// Character gap buffer port checker
// Port-level assertions on the request and response channels.
// ---------------------------------------------------------------------------
`include "char_gap_buffer_top_defines.svh"

module cgb_checker
   import cgb_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [OP_W-1:0]          req_operation,
   input logic [CHAR_W-1:0]        req_char_in,
   input logic signed [DIST_W-1:0] req_move_distance,
   input logic [POS_W-1:0]         req_read_position,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_status,
   input logic [OUT_W-1:0]         rsp_cursor_pos,
   input logic [OUT_W-1:0]         rsp_text_length,
   input logic [CHAR_W-1:0]        rsp_char_out
);

   logic                                 req_xfer;
   logic                                 req_wait;
   logic                                 rsp_stall;
   logic [OP_W+CHAR_W+DIST_W+POS_W-1:0]  req_word;
   logic [1+OUT_W+OUT_W+CHAR_W-1:0]      rsp_word;

   assign req_xfer  = req_valid && req_ready;
   assign req_wait  = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_word  = {req_operation, req_char_in, req_move_distance, req_read_position};
   assign rsp_word  = {rsp_status, rsp_cursor_pos, rsp_text_length, rsp_char_out};

   // A stalled response keeps its payload.
   `CGB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // A waiting request keeps its payload until it is taken.
   `CGB_ASSERT_NXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_word))

   // A refused operation never returns a character.
   `CGB_ASSERT_IMP(a_refused_no_char, clock, reset, rsp_valid && rsp_status, rsp_char_out == '0)

   // Only one operation is in flight: no request right after a transfer.
   `CGB_ASSERT_NXT(a_one_in_flight, clock, reset, req_xfer, !req_ready)

   // A response takes at least the decode cycle after its request.
   `CGB_ASSERT_NXT(a_no_early_rsp, clock, reset, req_xfer, !$rose(rsp_valid))

endmodule

bind char_gap_buffer_top cgb_checker u_cgb_checker (.*);
